// ===== hdl/pfs_pkg.sv =====
// ----------------------------------------------------------------------------
// pfs_pkg
// shared types and constants of the priced factor score top-n ranker
// ----------------------------------------------------------------------------
package pfs_pkg;

	// request modes
	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_CAND  = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	// register indexes
	localparam logic [1:0] REG_GLOBAL_MEAN = 2'd0;
	localparam logic [1:0] REG_PENALTY     = 2'd1;
	localparam logic [1:0] REG_SCORE_KIND  = 2'd2;

	// score kinds
	localparam logic KIND_MF  = 1'b0;
	localparam logic KIND_BPR = 1'b1;

	// exact accumulator width: four q16.16 products plus a shifted q8.8 offset
	localparam int ACC_W = 36;
	// q8.8 offset: three summed terms minus the penalty
	localparam int OFS_W = 20;

	typedef struct packed {
		logic [1:0]         mode;
		logic [15:0]        item_id;
		logic               skip;
		logic               item_trained;
		logic               user_trained;
		logic signed [15:0] bias;
		logic [15:0]        amount;
		logic signed [15:0] fallback_rating;
		logic signed [15:0] factor0;
		logic signed [15:0] factor1;
		logic signed [15:0] factor2;
		logic signed [15:0] factor3;
	} pfs_in_t;

	typedef struct packed {
		logic [5:0]         rank;
		logic [15:0]        chosen_item;
		logic signed [31:0] score;
		logic               occupied;
		logic               last;
	} pfs_out_t;

	// one position of the ranked list
	typedef struct packed {
		logic               filled;
		logic [15:0]        item;
		logic signed [31:0] score;
	} pfs_entry_t;

	// control broadcast to every list cell
	typedef struct packed {
		logic               clear;
		logic               insert;
		logic               rotate;
		logic signed [31:0] score;
		logic [15:0]        item;
	} pfs_cell_ctrl_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} pfs_state_t;

endpackage

// ===== hdl/pfs_lane.sv =====
// ----------------------------------------------------------------------------
// pfs_lane
// one factor lane: registered q8.8 by q8.8 product
// ----------------------------------------------------------------------------
module pfs_lane (
	input  logic               clk,
	input  logic               en,
	input  logic signed [15:0] user_factor,
	input  logic signed [15:0] item_factor,
	output logic signed [31:0] product_s1
);

	always_ff @(posedge clk) begin
		if (en) begin
			product_s1 <= user_factor * item_factor;
		end
	end

endmodule

// ===== hdl/pfs_merge.sv =====
// ----------------------------------------------------------------------------
// pfs_merge
// sums the lane products, when use_dot_s1 is set, with the offset and saturates to q16.16
// ----------------------------------------------------------------------------
module pfs_merge #(
	parameter int FACTORS = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             valid_s1,
	input  logic signed [31:0]               product_s1 [FACTORS],
	input  logic                             use_dot_s1,
	input  logic signed [pfs_pkg::OFS_W-1:0] offset_s1,
	input  logic [15:0]                      item_s1,
	output logic                             valid_s2,
	output logic signed [31:0]               score_s2,
	output logic [15:0]                      item_s2
);
	import pfs_pkg::*;

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7FFF_FFFF);
	localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(64'sh8000_0000);

	logic signed [ACC_W-1:0] dot;
	logic signed [ACC_W-1:0] acc;
	logic signed [31:0]      sat;

	always_comb begin
		dot = '0;
		for (int i = 0; i < FACTORS; i++) begin
			dot = dot + ACC_W'(product_s1[i]);
		end
		acc = (use_dot_s1 ? dot : '0) + (ACC_W'(offset_s1) <<< 8);
		if (acc > SAT_HI) begin
			sat = 32'sh7FFF_FFFF;
		end else if (acc < SAT_LO) begin
			sat = 32'sh8000_0000;
		end else begin
			sat = acc[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			score_s2 <= sat;
			item_s2  <= item_s1;
		end
	end

endmodule

// ===== hdl/pfs_cell.sv =====
// ----------------------------------------------------------------------------
// pfs_cell
// compare-shift cell of the ascending top-n list
// ----------------------------------------------------------------------------
module pfs_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pfs_pkg::pfs_cell_ctrl_t ctrl,
	input  pfs_pkg::pfs_entry_t     up,
	input  logic                    up_hit,
	output pfs_pkg::pfs_entry_t     entry_q,
	output logic                    hit
);
	import pfs_pkg::*;

	pfs_entry_t nxt;

	// the list is ascending, so hits form a run from position zero upward
	assign hit = ctrl.insert && (ctrl.score > entry_q.score);

	always_comb begin
		nxt = entry_q;
		if (ctrl.clear) begin
			nxt = '0;
		end else if (ctrl.rotate) begin
			nxt = up;
		end else if (ctrl.insert) begin
			if (up_hit) begin
				nxt = up;
			end else if (hit) begin
				nxt.filled = 1'b1;
				nxt.item   = ctrl.item;
				nxt.score  = ctrl.score;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else begin
			entry_q <= nxt;
		end
	end

endmodule

// ===== hdl/priced_factor_score_top_n.sv =====
// ----------------------------------------------------------------------------
// priced_factor_score_top_n
// scores candidate items for one user and keeps the best TOP_N of them
// ----------------------------------------------------------------------------
// usage:
//  req channel (valid/stall) carries start, candidate and readout items.
//  a start item loads the user vector, bias, budget and trained flag and
//  empties the list. candidates stream one per cycle while req_stall is
//  low: FACTORS multiplier lanes feed a merge stage, and the saturated
//  score passes the lane and merge registers into the compare-shift list.
//  a start or readout item is held off until candidates in flight have landed.
//  a readout item produces TOP_N items on the rsp channel, rank 0 first,
//  one per cycle while rsp_stall is low; the list rotates through its own
//  cells and comes back unchanged. req is stalled for the whole readout.
//  rsp has an output register: a stalled result holds and the readout waits.
//  reset empties the list, zeroes the user state and the registers.
//  registers sit on the apb port at byte addresses 0, 4 and 8; write only
//  while idle.
// ----------------------------------------------------------------------------
module priced_factor_score_top_n #(
	parameter int FACTORS = 4,
	parameter int TOP_N   = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              req_valid,
	output logic              req_stall,
	input  pfs_pkg::pfs_in_t  req_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output pfs_pkg::pfs_out_t rsp_data
);
	import pfs_pkg::*;

	localparam int CNT_W = (TOP_N > 1) ? $clog2(TOP_N) : 1;

	// configuration
	logic signed [15:0] global_mean_q;
	logic signed [15:0] penalty_q;
	logic               score_kind_q;

	// user state
	logic signed [15:0] user_factor_q [FACTORS];
	logic signed [15:0] user_bias_q;
	logic [15:0]        user_budget_q;
	logic               user_known_q;

	// pipeline
	logic                    valid_s1;
	logic                    use_dot_s1;
	logic signed [OFS_W-1:0] offset_s1;
	logic [15:0]             item_s1;
	logic signed [31:0]      product_s1 [FACTORS];
	logic                    valid_s2;
	logic signed [31:0]      score_s2;
	logic [15:0]             item_s2;

	// readout
	pfs_state_t       state_q, state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic             rd_step;
	logic             rsp_valid_q;
	pfs_out_t         rsp_q;

	logic               req_take;
	logic               cfg_wr;
	logic               known;
	logic               over;
	logic signed [OFS_W-1:0] base;
	logic signed [15:0] item_f [4];

	pfs_cell_ctrl_t ctrl;
	pfs_entry_t     entries [TOP_N];
	logic [TOP_N-1:0] hits;
	logic [TOP_N-1:0] filled_vec;
	logic [TOP_N-1:0] filled_up;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			global_mean_q <= '0;
			penalty_q     <= '0;
			score_kind_q  <= KIND_MF;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_GLOBAL_MEAN: global_mean_q <= pwdata[15:0];
				REG_PENALTY:     penalty_q     <= pwdata[15:0];
				REG_SCORE_KIND:  score_kind_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_GLOBAL_MEAN: prdata = 32'(global_mean_q);
			REG_PENALTY:     prdata = 32'(penalty_q);
			REG_SCORE_KIND:  prdata = {31'd0, score_kind_q};
			default:         prdata = '0;
		endcase
	end

	// ---------------- request side ----------------
	assign item_f[0] = req_data.factor0;
	assign item_f[1] = req_data.factor1;
	assign item_f[2] = req_data.factor2;
	assign item_f[3] = req_data.factor3;

	assign req_take = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FACTORS; i++) begin
				user_factor_q[i] <= '0;
			end
			user_bias_q   <= '0;
			user_budget_q <= '0;
			user_known_q  <= 1'b0;
		end else if (req_take && req_data.mode == MODE_START) begin
			for (int i = 0; i < FACTORS; i++) begin
				user_factor_q[i] <= item_f[i];
			end
			user_bias_q   <= req_data.bias;
			user_budget_q <= req_data.amount;
			user_known_q  <= req_data.user_trained;
		end
	end

	// q8.8 part of the score, formed while the lanes multiply
	assign known = user_known_q && req_data.item_trained;
	assign over  = user_budget_q < req_data.amount;

	always_comb begin
		if (score_kind_q == KIND_BPR) begin
			base = '0;
		end else if (known) begin
			base = OFS_W'(global_mean_q) + OFS_W'(user_bias_q) + OFS_W'(req_data.bias);
		end else begin
			base = OFS_W'(req_data.fallback_rating);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req_take && req_data.mode == MODE_CAND && !req_data.skip;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take && req_data.mode == MODE_CAND) begin
			use_dot_s1 <= (score_kind_q == KIND_BPR) || known;
			offset_s1  <= base - (over ? OFS_W'(penalty_q) : OFS_W'(0));
			item_s1    <= req_data.item_id;
		end
	end

	for (genvar g = 0; g < FACTORS; g++) begin : g_lane
		pfs_lane u_lane (
			.clk        (clk),
			.en         (req_take && req_data.mode == MODE_CAND),
			.user_factor(user_factor_q[g]),
			.item_factor(item_f[g]),
			.product_s1 (product_s1[g])
		);
	end

	pfs_merge #(
		.FACTORS(FACTORS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.product_s1(product_s1),
		.use_dot_s1(use_dot_s1),
		.offset_s1 (offset_s1),
		.item_s1   (item_s1),
		.valid_s2  (valid_s2),
		.score_s2  (score_s2),
		.item_s2   (item_s2)
	);

	// ---------------- ranked list ----------------
	always_comb begin
		ctrl.clear  = req_take && req_data.mode == MODE_START;
		ctrl.insert = valid_s2;
		ctrl.rotate = rd_step;
		ctrl.score  = score_s2;
		ctrl.item   = item_s2;
	end

	for (genvar g = 0; g < TOP_N; g++) begin : g_cell
		pfs_entry_t up;
		logic       up_hit;
		if (g == TOP_N - 1) begin : g_top
			// top cell wraps to position zero for readout rotation
			assign up     = entries[0];
			assign up_hit = 1'b0;
		end else begin : g_mid
			assign up     = entries[g+1];
			assign up_hit = hits[g+1];
		end
		pfs_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.up     (up),
			.up_hit (up_hit),
			.entry_q(entries[g]),
			.hit    (hits[g])
		);
		assign filled_vec[g] = entries[g].filled;
	end

	assign filled_up = filled_vec << 1;

	// ---------------- readout sequencer ----------------
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_take && req_data.mode == MODE_READ) begin
					state_nxt = ST_READ;
				end
			end
			ST_READ: begin
				if (rd_step && cnt_q == CNT_W'(TOP_N - 1)) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		rd_step   = (state_q == ST_READ) && (!rsp_valid_q || !rsp_stall);
		// start and readout wait for candidates in flight
		req_stall = (state_q == ST_READ) ||
			(req_data.mode != MODE_CAND && (valid_s1 || valid_s2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (rd_step) begin
				cnt_q       <= (cnt_q == CNT_W'(TOP_N - 1)) ? '0 : cnt_q + 1'b1;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_step) begin
			rsp_q.rank        <= 6'(cnt_q);
			rsp_q.chosen_item <= entries[0].filled ? entries[0].item : '0;
			rsp_q.score       <= entries[0].filled ? entries[0].score : '0;
			rsp_q.occupied    <= entries[0].filled;
			rsp_q.last        <= (cnt_q == CNT_W'(TOP_N - 1));
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// ---------------- checks ----------------
	a_no_take_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |-> state_q == ST_IDLE)
		else $error("request taken during readout");

	a_pipe_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(req_take && req_data.mode != MODE_CAND) |-> (!valid_s1 && !valid_s2))
		else $error("start or readout taken with candidates in flight");

	a_list_packed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> (filled_up & ~filled_vec) == '0)
		else $error("filled positions not contiguous at top of list");

	a_insert_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !rd_step)
		else $error("insert collides with readout rotation");

	a_read_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_step && cnt_q == CNT_W'(TOP_N - 1)) |=> (state_q == ST_IDLE && cnt_q == '0))
		else $error("readout did not finish after last position");

endmodule
